// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VPO_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VPO_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/vpo_pkg.sv =====
package vpo_pkg;

    localparam int OCTAVE_SPAN = 10;
    localparam int FRAC_BITS   = 15;

    localparam int CV_W     = 16;
    localparam int FREQ_W   = 24;
    localparam int PW_W     = 17;
    localparam int SP_W     = 32;
    localparam int GAIN_W   = 32;
    localparam int PHASE_W  = 32;
    localparam int PROD_W   = 48;
    localparam int EXPO_W   = 22;
    localparam int SHIFT_W  = 7;
    localparam int STEP_W   = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SP_W-1:0] SP_RESET = 32'd89478;

    localparam logic signed [1:0] LEVEL_HIGH = 2'sb01;
    localparam logic signed [1:0] LEVEL_LOW  = 2'sb11;

    // c[k] ~ 2^(2^-k) in Q1.31, k = 1..FRAC_BITS
    typedef logic [FRAC_BITS:1][GAIN_W-1:0] exp_tab_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [FREQ_W-1:0] base_freq;
        logic              sync;
        logic [PW_W-1:0]   pulse_width;
    } vpo_task_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        int          i;
        n = n_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (i = 0; i < 32; i++)
        begin
            if (b > n)
            begin
                b = b >> 2;
            end
        end
        for (i = 0; i < 32; i++)
        begin
            if (b != 64'd0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    t;
        logic [63:0] c;
        int          k;
        t = '0;
        c = 64'h1_0000_0000;
        for (k = 1; k <= FRAC_BITS; k++)
        begin
            c = isqrt64(c << 31);
            t[k] = c[GAIN_W-1:0];
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== rtl/core/vpo_front.sv =====
module vpo_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [vpo_pkg::CV_W-1:0] pitch_cv,
    input  logic [vpo_pkg::FREQ_W-1:0]   base_freq,
    input  logic                         sync,
    input  logic [vpo_pkg::PW_W-1:0]     pulse_width,
    output logic                         q_push,
    input  logic                         q_full,
    output vpo_pkg::vpo_task_t           q_data
);
    import vpo_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [FRAC_BITS-1:0]      frac_reg, frac_next;
    logic signed [SHIFT_W-1:0] shift_reg, shift_next;
    logic [GAIN_W-1:0]         g_reg, g_next;
    logic [FREQ_W-1:0]         base_freq_reg, base_freq_next;
    logic                      sync_reg, sync_next;
    logic [PW_W-1:0]           width_reg, width_next;

    logic signed [EXPO_W-1:0]  expo;
    logic signed [SHIFT_W-1:0] shift_in;
    logic [63:0]               prod;
    logic [63:0]               prod_rnd;
    logic [5:0]                sh_l;
    logic [5:0]                sh_r;
    logic [63:0]               wide_l;
    logic [GAIN_W:0]           rnd_r;
    logic [GAIN_W-1:0]         gain;

    // Offset the exponent so it is never negative; integer part then sits above FRAC_BITS
    assign expo = EXPO_W'(pitch_cv) * EXPO_W'(OCTAVE_SPAN)
                + EXPO_W'(OCTAVE_SPAN * 32768);
    assign shift_in = $signed(SHIFT_W'(expo >>> FRAC_BITS)) - SHIFT_W'(OCTAVE_SPAN + 10);

    assign prod     = 64'(g_reg) * 64'(EXP_TAB[step_reg]);
    assign prod_rnd = prod + 64'(1 << 30);

    // Take the Q1.31 fraction gain to Q11.21: round on right shift, saturate on left
    always_comb
    begin
        sh_l   = shift_reg[5:0];
        sh_r   = 6'(-shift_reg);
        wide_l = 64'(g_reg) << sh_l;
        rnd_r  = (GAIN_W+1)'(g_reg) + ((GAIN_W+1)'(1) << (sh_r - 6'd1));
        if (shift_reg >= 0)
        begin
            gain = (wide_l[63:GAIN_W] != '0) ? '1 : wide_l[GAIN_W-1:0];
        end
        else
        begin
            gain = GAIN_W'(rnd_r >> sh_r);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        frac_next      = frac_reg;
        shift_next     = shift_reg;
        g_next         = g_reg;
        base_freq_next = base_freq_reg;
        sync_next      = sync_reg;
        width_next     = width_reg;
        q_push         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (push)
                begin
                    step_next      = STEP_W'(1);
                    frac_next      = expo[FRAC_BITS-1:0];
                    shift_next     = shift_in;
                    g_next         = GAIN_W'(64'h8000_0000);
                    base_freq_next = base_freq;
                    sync_next      = sync;
                    width_next     = pulse_width;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // One fraction bit per cycle, most significant first
                if (frac_reg[FRAC_BITS-1])
                begin
                    g_next = prod_rnd[62:31];
                end
                frac_next = frac_reg << 1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(FRAC_BITS))
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign full               = (state_reg != ST_IDLE);
    assign q_data.gain        = gain;
    assign q_data.base_freq   = base_freq_reg;
    assign q_data.sync        = sync_reg;
    assign q_data.pulse_width = width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg      <= frac_next;
        shift_reg     <= shift_next;
        g_reg         <= g_next;
        base_freq_reg <= base_freq_next;
        sync_reg      <= sync_next;
        width_reg     <= width_next;
    end

endmodule

// ===== rtl/core/vpo_queue.sv =====
module vpo_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  vpo_pkg::vpo_task_t din,
    input  logic               pop,
    output logic               empty,
    output vpo_pkg::vpo_task_t dout
);
    import vpo_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    vpo_task_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/core/vpo_back.sv =====
module vpo_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vpo_pkg::vpo_task_t         q_data,
    input  logic                       q_empty,
    output logic                       q_pop,
    input  logic [vpo_pkg::SP_W-1:0]   sample_period,
    input  logic                       pop,
    output logic                       empty,
    output logic signed [1:0]          level
);
    import vpo_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_P = 3'd1;
    localparam logic [2:0] ST_MUL_G = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]          state_reg, state_next;
    vpo_task_t           task_reg, task_next;
    logic [PROD_W-1:0]   p_reg, p_next;
    logic [63:0]         hi_reg, hi_next;
    logic [63:0]         lo_reg, lo_next;
    logic [PHASE_W-1:0]  inc_reg, inc_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [1:0]   level_reg, level_next;

    logic [59:0]         inc_sum;
    logic [PHASE_W-1:0]  phase_new;
    logic                load;

    assign inc_sum = 60'(hi_reg >> 5)
                   + 60'((60'(hi_reg[4:0]) + 60'(lo_reg >> 16)) >> 5);
    assign phase_new = task_reg.sync ? '0 : phase_reg + inc_reg;

    always_comb
    begin
        state_next = state_reg;
        task_next  = task_reg;
        p_next     = p_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        inc_next   = inc_reg;
        phase_next = phase_reg;
        level_next = level_reg;
        q_pop      = 1'b0;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    task_next  = q_data;
                    state_next = ST_MUL_P;
                end
            end
            ST_MUL_P:
            begin
                p_next = PROD_W'((56'(task_reg.base_freq) * 56'(sample_period)) >> 8);
                state_next = ST_MUL_G;
            end
            ST_MUL_G:
            begin
                hi_next    = 64'(p_reg) * 64'(task_reg.gain[31:16]);
                lo_next    = 64'(p_reg) * 64'(task_reg.gain[15:0]);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                // Saturate just below one cycle
                inc_next   = (inc_sum[59:PHASE_W] != '0) ? '1 : inc_sum[PHASE_W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register frees up
                if (!out_valid_reg || pop)
                begin
                    load       = 1'b1;
                    phase_next = phase_new;
                    level_next = ((PHASE_W+1)'(phase_new) < {task_reg.pulse_width, 16'b0})
                               ? LEVEL_HIGH : LEVEL_LOW;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !pop) || load;
    assign empty          = !out_valid_reg;
    assign level          = level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg  <= task_next;
        p_reg     <= p_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        inc_reg   <= inc_next;
        level_reg <= level_next;
    end

endmodule

// ===== rtl/core/pulse_oscillator_vpo_unit.sv =====
// Flow: the front end takes no new sample until its 15-step fraction gain loop on
// the multiplier has finished and the result has gone into the queue; the back end
// (product, gain, sum and done states) overlaps it, and either side can stall.
// Reset: phase to zero, sample_period to 89478 (about 1/48000 s), queue and
// output slot empty; the block can take a push as soon as reset is released.
module pulse_oscillator_vpo_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic signed [vpo_pkg::CV_W-1:0]  pitch_cv,
    input  logic [vpo_pkg::FREQ_W-1:0]       base_freq,
    input  logic                             sync,
    input  logic [vpo_pkg::PW_W-1:0]         pulse_width,
    output logic                             empty,
    input  logic                             pop,
    output logic signed [1:0]                level,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vpo_pkg::SP_W-1:0]         cfg_data
);
    import vpo_pkg::*;

    logic [SP_W-1:0] sample_period_reg, sample_period_next;
    vpo_task_t       fq_din;
    vpo_task_t       fq_dout;
    logic            fq_push;
    logic            fq_full;
    logic            fq_pop;
    logic            fq_empty;

    assign cfg_ready          = 1'b1;
    assign sample_period_next = (cfg_valid && cfg_ready) ? cfg_data : sample_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= SP_RESET;
        end
        else
        begin
            sample_period_reg <= sample_period_next;
        end
    end

    vpo_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pitch_cv    (pitch_cv),
        .base_freq   (base_freq),
        .sync        (sync),
        .pulse_width (pulse_width),
        .q_push      (fq_push),
        .q_full      (fq_full),
        .q_data      (fq_din)
    );

    vpo_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .full  (fq_full),
        .din   (fq_din),
        .pop   (fq_pop),
        .empty (fq_empty),
        .dout  (fq_dout)
    );

    vpo_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (fq_dout),
        .q_empty       (fq_empty),
        .q_pop         (fq_pop),
        .sample_period (sample_period_reg),
        .pop           (pop),
        .empty         (empty),
        .level         (level)
    );

endmodule

// ===== rtl/core/vpo_checker.sv =====
`include "assert_macros.svh"

module vpo_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input logic              pop,
    input logic              empty,
    input logic signed [1:0] level
);

    // A waiting result stays put until popped
    `VPO_ASSERT_NEXT(a_result_hold, clk, rst_n, !empty && !pop, !empty && $stable(level), "result changed before pop")

    // Only the two pulse codes ever appear
    `VPO_ASSERT_NOW(a_level_code, clk, rst_n, !empty, level == 2'b01 || level == 2'b11, "level is neither +1 nor -1")

    // Front end goes busy right after taking a sample
    `VPO_ASSERT_NEXT(a_busy_after_push, clk, rst_n, push && !full, full, "front end not busy after accepted push")

endmodule

bind pulse_oscillator_vpo_unit vpo_checker u_vpo_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (full),
    .pop   (pop),
    .empty (empty),
    .level (level)
);

// ===== tb/sv/pulse_oscillator_vpo_unit_tb.sv =====
module pulse_oscillator_vpo_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import vpo_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 30;
    localparam int IDLE_PCT = 7;
    localparam int MAX_PRINTS = 40;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic signed [CV_W-1:0]   pitch_cv = '0;
    logic [FREQ_W-1:0]        base_freq = '0;
    logic                     sync = 1'b0;
    logic [PW_W-1:0]          pulse_width = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic signed [1:0]        level;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [SP_W-1:0]          cfg_data = '0;

    // 2^(2^-k) in Q1.31, entry 0 holds 2.0
    logic [63:0]              octave_root_tab [0:FRAC_BITS];
    logic [SP_W-1:0]          period_q = SP_RESET;
    logic [PHASE_W-1:0]       phase_q = '0;
    logic signed [1:0]        expected_levels [$];

    bit                       quiet = 1'b0;
    int                       cycles = 0;
    int                       errors = 0;
    int                       items_sent = 0;
    int                       results_checked = 0;
    int                       cfg_writes = 0;
    int                       sync_count = 0;
    int                       sat_count = 0;
    int                       wrap_count = 0;

    pulse_oscillator_vpo_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pitch_cv    (pitch_cv),
        .base_freq   (base_freq),
        .sync        (sync),
        .pulse_width (pulse_width),
        .empty       (empty),
        .pop         (pop),
        .level       (level),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d levels outstanding", cycles,
                     expected_levels.size());
            $display("pulse_oscillator_vpo_unit: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (errors < MAX_PRINTS)
        begin
            $display("%0t ns: %s", $realtime, msg);
        end
        errors++;
    endtask

    function automatic logic [31:0] floor_root(input logic [63:0] n);
        logic [31:0] r;
        logic [64:0] t;
        int          b;
        r = '0;
        for (b = 31; b >= 0; b--)
        begin
            t = {33'd0, r} | (65'd1 << b);
            if (t * t <= {1'b0, n})
            begin
                r = t[31:0];
            end
        end
        return r;
    endfunction

    task automatic build_root_table();
        int k;
        octave_root_tab[0] = 64'h1_0000_0000;
        for (k = 1; k <= FRAC_BITS; k++)
        begin
            octave_root_tab[k] = {32'd0, floor_root(octave_root_tab[k-1] << 31)};
        end
    endtask

    // Q1.15 pitch to Q11.21 gain, 2^(OCTAVE_SPAN * cv)
    function automatic logic [GAIN_W-1:0] cv_to_gain(input logic signed [CV_W-1:0] cv);
        int          biased;
        int          ip;
        int          sh;
        int          k;
        logic [14:0] fr;
        logic [95:0] g;
        biased = int'(cv) * OCTAVE_SPAN + OCTAVE_SPAN * 32768;
        ip = (biased >> FRAC_BITS) - OCTAVE_SPAN;
        fr = biased[14:0];
        g = 96'd1 << 31;
        for (k = 1; k <= FRAC_BITS; k++)
        begin
            if (fr[FRAC_BITS-k])
            begin
                g = (g * octave_root_tab[k] + (96'd1 << 30)) >> 31;
            end
        end
        sh = ip - 10;
        if (sh >= 0)
        begin
            if (sh >= 32 || g > (96'hFFFF_FFFF >> sh))
            begin
                return '1;
            end
            return GAIN_W'(g << sh);
        end
        sh = -sh;
        if (sh >= 40)
        begin
            return '0;
        end
        return GAIN_W'((g + (96'd1 << (sh - 1))) >> sh);
    endfunction

    function automatic logic signed [1:0] predict_level(input logic signed [CV_W-1:0] cv,
                                                         input logic [FREQ_W-1:0] freq,
                                                         input logic sy,
                                                         input logic [PW_W-1:0] pw);
        logic [95:0]        p;
        logic [95:0]        prod;
        logic [PHASE_W-1:0] inc;
        logic [PHASE_W:0]   sum;
        p = ({72'd0, freq} * {64'd0, period_q}) >> 8;
        prod = (p * {64'd0, cv_to_gain(cv)}) >> 21;
        if (prod > 96'hFFFF_FFFF)
        begin
            inc = '1;
            sat_count++;
        end
        else
        begin
            inc = prod[PHASE_W-1:0];
        end
        if (sy)
        begin
            phase_q = '0;
            sync_count++;
        end
        else
        begin
            sum = {1'b0, phase_q} + {1'b0, inc};
            if (sum[PHASE_W])
            begin
                wrap_count++;
            end
            phase_q = sum[PHASE_W-1:0];
        end
        return ({1'b0, phase_q} < {pw, 16'd0}) ? LEVEL_HIGH : LEVEL_LOW;
    endfunction

    // Hold push high across back-to-back transactions; drop it only for a gap.
    task automatic send_sample(input logic signed [CV_W-1:0] cv, input logic [FREQ_W-1:0] freq,
                               input logic sy, input logic [PW_W-1:0] pw);
        if (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        push <= 1'b1;
        pitch_cv <= cv;
        base_freq <= freq;
        sync <= sy;
        pulse_width <= pw;
        do @(posedge clk); while (full);
        expected_levels.push_back(predict_level(cv, freq, sy, pw));
        items_sent++;
    endtask

    task automatic wait_for_drain();
        push <= 1'b0;
        @(posedge clk);
        while (expected_levels.size() != 0) @(posedge clk);
    endtask

    task automatic write_sample_period(input logic [SP_W-1:0] value);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        period_q = value;
        cfg_writes++;
    endtask

    task automatic send_random_full();
        logic [PW_W-1:0] pw;
        case ($urandom_range(3))
            0: pw = PW_W'($urandom_range(131071));
            1: pw = PW_W'($urandom_range(4));
            default: pw = PW_W'($urandom_range(65536));
        endcase
        if (pw < 5)
        begin
            case (pw)
                0: pw = 17'd0;
                1: pw = 17'd1;
                2: pw = 17'd65535;
                3: pw = 17'd65536;
                default: pw = 17'd131071;
            endcase
        end
        send_sample(CV_W'($urandom_range(65535)),
                    FREQ_W'($urandom & ((32'd1 << $urandom_range(1, 24)) - 1)),
                    $urandom_range(11) == 0, pw);
    endtask

    // Plausible audio: 20 Hz..20 kHz, pitch within a few octaves, rare sync.
    task automatic send_random_audio();
        send_sample(CV_W'(int'($urandom_range(13106)) - 6553),
                    FREQ_W'($urandom_range(20 * 256, 20000 * 256)),
                    $urandom_range(39) == 0, PW_W'($urandom_range(65536)));
    endtask

    task automatic test_directed_extremes();
        send_sample(16'sh0000, 24'd112640, 1'b0, 17'd32768);
        send_sample(-16'sd32768, 24'hFF_FFFF, 1'b0, 17'd65535);
        send_sample(16'sd32767, 24'hFF_FFFF, 1'b0, 17'd65536);
        send_sample(16'sd32767, 24'hFF_FFFF, 1'b0, 17'd131071);
        send_sample(-16'sd1, 24'd0, 1'b0, 17'd0);
        send_sample(16'sd1, 24'd1, 1'b0, 17'd1);
        send_sample(-16'sd32768, 24'd0, 1'b1, 17'd0);
        send_sample(-16'sd32768, 24'd0, 1'b1, 17'd1);
        send_sample(16'sd32767, 24'hFF_FFFF, 1'b1, 17'd131071);
        send_sample(16'sd3277, 24'h80_0000, 1'b0, 17'h1_0001);
        send_sample(-16'sd3277, 24'h7F_FFFF, 1'b0, 17'h0_AAAA);
        send_sample(16'sh5555, 24'h55_5555, 1'b0, 17'h1_5555);
        send_sample(16'shAAAA, 24'hAA_AAAA, 1'b0, 17'h0_AAAA);
    endtask

    // Free-running tone long enough to wrap several times, then resync.
    task automatic test_sync_and_wrap();
        int i;
        for (i = 0; i < 12; i++)
        begin
            send_sample(16'sd0, 24'(20000 * 256), i == 7, 17'd32768);
        end
    endtask

    task automatic test_period_sweep();
        logic [SP_W-1:0] periods [0:4];
        int              i;
        periods[0] = 32'd0;
        periods[1] = 32'd1;
        periods[2] = 32'hFFFF_FFFF;
        periods[3] = 32'h8000_0000;
        periods[4] = $urandom;
        for (i = 0; i < 5; i++)
        begin
            write_sample_period(periods[i]);
            send_sample(16'sd32767, 24'hFF_FFFF, 1'b0, 17'd65536);
            send_sample(-16'sd32768, 24'd1, 1'b0, 17'd1);
            send_sample(16'sd0, 24'd256000, 1'b0, 17'd32768);
            send_sample(CV_W'($urandom_range(65535)), FREQ_W'($urandom), 1'b0,
                        PW_W'($urandom_range(65536)));
        end
        write_sample_period(SP_RESET);
    endtask

    task automatic test_random_audio();
        logic [SP_W-1:0] periods [0:3];
        int              i;
        int              n;
        periods[0] = SP_RESET;
        periods[1] = 32'd97391;
        periods[2] = 32'd44739;
        periods[3] = 32'd178957;
        for (i = 0; i < 4; i++)
        begin
            write_sample_period(periods[i]);
            for (n = 0; n < 150; n++)
            begin
                if ($urandom_range(99) < 85)
                begin
                    send_random_audio();
                end
                else
                begin
                    send_random_full();
                end
            end
        end
    endtask

    // Back-to-back traffic with both sides always ready.
    task automatic test_random_quiet();
        int n;
        write_sample_period($urandom_range(20000, 200000));
        quiet = 1'b1;
        for (n = 0; n < 300; n++)
        begin
            if (n[0])
            begin
                send_random_audio();
            end
            else
            begin
                send_random_full();
            end
        end
        wait_for_drain();
        quiet = 1'b0;
    endtask

    task automatic test_random_full();
        logic [SP_W-1:0] periods [0:3];
        int              i;
        int              n;
        periods[0] = 32'hFFFF_FFFF;
        periods[1] = 32'd0;
        periods[2] = $urandom;
        periods[3] = $urandom & 32'h000F_FFFF;
        for (i = 0; i < 4; i++)
        begin
            write_sample_period(periods[i]);
            for (n = 0; n < 150; n++)
            begin
                send_random_full();
            end
        end
    endtask

    initial
    begin
        logic signed [1:0] want;
        int                stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (expected_levels.size() == 0)
                begin
                    report_mismatch($sformatf("level %0d with no sample outstanding", level));
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (level !== want)
                    begin
                        report_mismatch($sformatf("level %0d, expected %0d (result %0d)",
                                                  level, want, results_checked));
                    end
                    results_checked++;
                end
            end
            if (stall > 0)
            begin
                stall--;
            end
            else if (!quiet && $urandom_range(99) < IDLE_PCT)
            begin
                stall = $urandom_range(1, 8);
            end
            pop <= (stall == 0);
        end
    end

    initial
    begin
        build_root_table();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_extremes();
        test_sync_and_wrap();
        test_period_sweep();
        test_random_audio();
        test_random_quiet();
        test_random_full();
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d samples, %0d levels checked, %0d period writes",
                 items_sent, results_checked, cfg_writes);
        $display("  including %0d syncs, %0d phase wraps, %0d saturated increments",
                 sync_count, wrap_count, sat_count);
        if (errors == 0)
        begin
            $display("pulse_oscillator_vpo_unit: match");
        end
        else
        begin
            $display("pulse_oscillator_vpo_unit: mismatch");
        end
        $finish;
    end

endmodule
